FILE: rtl/core/plm_pkg.sv
// Package for the pooled linked list manager.
// Pool sizing, link encoding, codes and transaction payload types.
// No dependencies.
package plm_pkg;

    localparam int POOL_SLOTS = 64;
    localparam int IDX_W      = $clog2(POOL_SLOTS);
    localparam int LINK_W     = $clog2(POOL_SLOTS + 1);
    localparam int CNT_W      = $clog2(POOL_SLOTS + 1);
    localparam int SLOT_W     = 6;
    localparam int COUNT_W    = 7;

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_SLOTS);

    typedef enum logic {
        OP_ALLOC  = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_FULL       = 2'd1,
        STAT_BAD_DELETE = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic              operation;
        logic [SLOT_W-1:0] slot_index;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0]  result_slot;
        logic [SLOT_W-1:0]  head_slot;
        logic               list_empty;
        logic [COUNT_W-1:0] used_count;
        logic [1:0]         status;
    } t_out_item;

    // Requests from the sequencer to the link store.
    // The next entry carries the slot's in-use flag beside its link.
    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              nx_we;
        logic [IDX_W-1:0]  nx_waddr;
        logic [LINK_W-1:0] nx_wdata;
        logic              nx_wused;
        logic              pv_we;
        logic [IDX_W-1:0]  pv_waddr;
        logic [LINK_W-1:0] pv_wdata;
    } t_mem_req;

    // Read data, valid in the cycle after rd_en, held until the next read.
    typedef struct packed {
        logic              used;
        logic [LINK_W-1:0] nx;
        logic [LINK_W-1:0] pv;
    } t_mem_rsp;

    typedef struct packed {
        logic      valid;
        t_out_item data;
    } t_result;

endpackage

FILE: rtl/core/plm_ram.sv
// Generic single-write, single-read synchronous RAM, read-first.
// Registered read; read data holds while i_re is low.
// No dependencies.
module plm_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

FILE: rtl/core/plm_link_store.sv
// Link store: next (with in-use flag) and prev link RAMs plus per-slot
// written flags. An unwritten next entry reads free, slot i linked to i+1.
// Depends on plm_pkg and plm_ram.
module plm_link_store
    import plm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_req,
    output t_mem_rsp o_rsp
);

    logic [POOL_SLOTS-1:0] r_written;
    logic [IDX_W-1:0]      r_rd_addr;
    logic                  r_rd_written;
    logic [LINK_W:0]       nx_q;
    logic [LINK_W-1:0]     pv_q;

    plm_ram #(
        .DEPTH(POOL_SLOTS),
        .WIDTH(LINK_W + 1)
    ) u_next_ram (
        .i_clk  (i_clk),
        .i_we   (i_req.nx_we),
        .i_waddr(i_req.nx_waddr),
        .i_wdata({i_req.nx_wused, i_req.nx_wdata}),
        .i_re   (i_req.rd_en),
        .i_raddr(i_req.rd_addr),
        .o_rdata(nx_q)
    );

    plm_ram #(
        .DEPTH(POOL_SLOTS),
        .WIDTH(LINK_W)
    ) u_prev_ram (
        .i_clk  (i_clk),
        .i_we   (i_req.pv_we),
        .i_waddr(i_req.pv_waddr),
        .i_wdata(i_req.pv_wdata),
        .i_re   (i_req.rd_en),
        .i_raddr(i_req.rd_addr),
        .o_rdata(pv_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_req.rd_en) begin
                // flag sampled before a same-cycle write, like the RAM
                r_rd_written <= r_written[i_req.rd_addr];
            end
            if (i_req.nx_we) begin
                r_written[i_req.nx_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_addr <= i_req.rd_addr;
        end
    end

    assign o_rsp.used = r_rd_written && nx_q[LINK_W];
    assign o_rsp.nx   = r_rd_written ? nx_q[LINK_W-1:0]
                                     : (LINK_W'(r_rd_addr) + LINK_W'(1));
    assign o_rsp.pv   = pv_q;

endmodule

FILE: rtl/core/plm_seq.sv
// Sequencer: list head, free head and count; drives the link store
// through read, then modify and write back. Depends on plm_pkg.
module plm_seq
    import plm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    output logic     o_in_ready,
    input  logic     i_slot_free,
    input  t_mem_rsp i_rsp,
    output t_mem_req o_req,
    output t_result  o_res
);

    t_state r_state, n_state;

    logic [LINK_W-1:0]     r_free_head, n_free_head;
    logic [LINK_W-1:0]     r_list_head, n_list_head;
    logic [CNT_W-1:0]      r_count, n_count;

    t_op               r_op;
    t_status           r_status, n_status;
    logic [IDX_W-1:0]  r_slot, n_slot;
    logic [SLOT_W-1:0] r_res_slot, n_res_slot;

    logic              accept;
    logic              commit;
    logic [31:0]       idx32;
    logic [IDX_W-1:0]  idx_s;
    logic              idx_in_range;
    logic              del_free;
    t_status           fin_status;
    logic [31:0]       head32;
    logic [31:0]       cnt32;
    logic              empty;

    assign accept       = i_in_valid && (r_state == ST_IDLE);
    assign commit       = (r_state == ST_FINISH) && i_slot_free;
    assign idx32        = 32'(i_in_item.slot_index);
    assign idx_s        = idx32[IDX_W-1:0];
    assign idx_in_range = (idx32 < 32'(POOL_SLOTS));

    // delete of a slot that the store reports free
    assign del_free   = (r_op == OP_DELETE) && (r_status == STAT_OK) && !i_rsp.used;
    assign fin_status = del_free ? STAT_BAD_DELETE : r_status;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs: handshake and memory requests
    always_comb begin
        o_in_ready = 1'b0;
        o_req      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    if (t_op'(i_in_item.operation) == OP_ALLOC) begin
                        if (r_free_head != LINK_NULL) begin
                            o_req.rd_en    = 1'b1;
                            o_req.rd_addr  = r_free_head[IDX_W-1:0];
                            o_req.pv_we    = 1'b1;
                            o_req.pv_waddr = r_free_head[IDX_W-1:0];
                            o_req.pv_wdata = LINK_NULL;
                        end
                    end else if (idx_in_range) begin
                        // read-first RAM returns the old entry; undone if the slot is free
                        o_req.rd_en    = 1'b1;
                        o_req.rd_addr  = idx_s;
                        o_req.nx_we    = 1'b1;
                        o_req.nx_waddr = idx_s;
                        o_req.nx_wdata = r_free_head;
                        o_req.nx_wused = 1'b0;
                    end
                end
            end
            ST_FINISH: begin
                if (commit) begin
                    if (fin_status == STAT_OK) begin
                        if (r_op == OP_ALLOC) begin
                            o_req.nx_we    = 1'b1;
                            o_req.nx_waddr = r_slot;
                            o_req.nx_wdata = r_list_head;
                            o_req.nx_wused = 1'b1;
                            if (r_list_head != LINK_NULL) begin
                                o_req.pv_we    = 1'b1;
                                o_req.pv_waddr = r_list_head[IDX_W-1:0];
                                o_req.pv_wdata = LINK_W'(r_slot);
                            end
                        end else begin
                            if (i_rsp.pv != LINK_NULL) begin
                                o_req.nx_we    = 1'b1;
                                o_req.nx_waddr = i_rsp.pv[IDX_W-1:0];
                                o_req.nx_wdata = i_rsp.nx;
                                o_req.nx_wused = 1'b1;
                            end
                            if (i_rsp.nx != LINK_NULL) begin
                                o_req.pv_we    = 1'b1;
                                o_req.pv_waddr = i_rsp.nx[IDX_W-1:0];
                                o_req.pv_wdata = i_rsp.pv;
                            end
                        end
                    end else if (del_free) begin
                        // put back the free slot's entry
                        o_req.nx_we    = 1'b1;
                        o_req.nx_waddr = r_slot;
                        o_req.nx_wdata = i_rsp.nx;
                        o_req.nx_wused = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        n_free_head = r_free_head;
        n_list_head = r_list_head;
        n_count     = r_count;
        n_status    = r_status;
        n_slot      = r_slot;
        n_res_slot  = r_res_slot;
        if (accept) begin
            if (t_op'(i_in_item.operation) == OP_ALLOC) begin
                n_slot = r_free_head[IDX_W-1:0];
                if (r_free_head == LINK_NULL) begin
                    n_status   = STAT_FULL;
                    n_res_slot = '0;
                end else begin
                    n_status   = STAT_OK;
                    n_res_slot = SLOT_W'(r_free_head);
                end
            end else begin
                n_slot     = idx_s;
                n_res_slot = i_in_item.slot_index;
                n_status   = idx_in_range ? STAT_OK : STAT_BAD_DELETE;
            end
        end
        if (r_state == ST_FINISH && fin_status == STAT_OK) begin
            if (r_op == OP_ALLOC) begin
                n_free_head = i_rsp.nx;
                n_list_head = LINK_W'(r_slot);
                n_count     = r_count + CNT_W'(1);
            end else begin
                if (i_rsp.pv == LINK_NULL) begin
                    n_list_head = i_rsp.nx;
                end
                n_free_head = LINK_W'(r_slot);
                if (r_count != '0) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_free_head <= '0;
            r_list_head <= LINK_NULL;
            r_count     <= '0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_free_head <= n_free_head;
                r_list_head <= n_list_head;
                r_count     <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= t_op'(i_in_item.operation);
            r_status   <= n_status;
            r_slot     <= n_slot;
            r_res_slot <= n_res_slot;
        end
    end

    // result reflects the state after the step
    assign head32 = 32'(n_list_head);
    assign cnt32  = 32'(n_count);
    assign empty  = (n_list_head == LINK_NULL);

    always_comb begin
        o_res                  = '0;
        o_res.valid            = commit;
        o_res.data.result_slot = r_res_slot;
        o_res.data.head_slot   = empty ? '0 : head32[SLOT_W-1:0];
        o_res.data.list_empty  = empty;
        o_res.data.used_count  = cnt32[COUNT_W-1:0];
        o_res.data.status      = fin_status;
    end

endmodule

FILE: rtl/core/pooled_linked_list_manager_unit.sv
// Top level of the pooled linked list manager: sequencer, link store and
// the output register. Depends on plm_pkg, plm_seq and plm_link_store.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out_item)
//
// Each transaction has an accept cycle that issues the link RAM
// read (and one write that does not depend on it), then a finish cycle that
// writes the neighbours back and loads the result. A delete's early write
// is put back in the finish cycle when the read shows the slot free.
// The registered RAM read and the single write port per link RAM
// set this split into an accept and a finish step.
// Synchronous active-low reset: empty list, free chain 0..POOL_SLOTS-1; no
// clearing pass, unwritten next entries read as free and chained.
// The output register lets a new transaction enter while a result waits;
// the finish cycle stalls only while that register is full and not taken.
module pooled_linked_list_manager_unit
    import plm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_mem_req  mem_req;
    t_mem_rsp  mem_rsp;
    t_result   res;
    logic      slot_free;

    logic      r_out_valid;
    t_out_item r_out_data;

    // result register is free when empty or being drained this cycle
    assign slot_free = !r_out_valid || i_out_ready;

    plm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_data),
        .o_in_ready (o_in_ready),
        .i_slot_free(slot_free),
        .i_rsp      (mem_rsp),
        .o_req      (mem_req),
        .o_res      (res)
    );

    plm_link_store u_links (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mem_req),
        .o_rsp  (mem_rsp)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_out_data <= res.data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: rtl/core/plm_checker.sv
// Port-level checks for pooled_linked_list_manager_unit, with its bind.
// Depends on plm_pkg.
module plm_checker
    import plm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    localparam logic [31:0]        FULL32    = 32'(POOL_SLOTS);
    localparam logic [COUNT_W-1:0] FULL_CNT  = FULL32[COUNT_W-1:0];

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    // one transaction in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted on back-to-back cycles");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == STAT_FULL
            |-> o_out_data.used_count == FULL_CNT && o_out_data.result_slot == '0)
        else $error("pool full reported with slots free");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.list_empty
            |-> o_out_data.head_slot == '0 && o_out_data.used_count == '0)
        else $error("empty list with a head or nonzero count");

endmodule

bind pooled_linked_list_manager_unit plm_checker u_plm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);
